@@ rtl/tjfk_pkg.sv @@
// shared constants, types and cordic table for the leg forward kinematics block
package tjfk_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int XY_W          = 34;
    localparam int Z_W           = 32;
    localparam int ANG_W         = 18;
    localparam int LINK_W        = 13;
    localparam int PROD_W        = 48;
    localparam int CORD_LAT      = CORDIC_STAGES + 2;
    localparam int COMB_LAT      = 4;
    localparam int TOTAL_LAT     = CORD_LAT + COMB_LAT;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd11520;
    localparam logic signed [XY_W-1:0]  CORDIC_K     = 34'sd652032875;

    localparam logic [1:0] REG_HIP   = 2'd0;
    localparam logic [1:0] REG_THIGH = 2'd1;
    localparam logic [1:0] REG_FOOT  = 2'd2;

    typedef struct packed {
        logic signed [XY_W-1:0] cos_val;
        logic signed [XY_W-1:0] sin_val;
    } trig_t;

    function automatic logic signed [Z_W-1:0] atan_val(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            17: v = 32'sd1833;
            18: v = 32'sd917;
            19: v = 32'sd458;
            20: v = 32'sd229;
            21: v = 32'sd115;
            22: v = 32'sd57;
            23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/three_joint_leg_forward_kinematics_top.sv @@
// top level of the three-joint leg forward kinematics block
// usage:
//   s_ channel carries one item of joint angles (hip, knee, ankle relative
//   to knee), signed 1/128 degree; m_ channel returns foot x, y, z in
//   1/16 mm, saturated to 16 bits, plus a clipped flag
//   link lengths are written over the apb port at 0x0, 0x4, 0x8 (13 bits)
//   and the user changes them only while no item is in flight (unchecked)
// pipeline: one register per cordic stage, the wrap/fold and sign registers,
//   and four stages of link products, reach, coordinate products, rounding
// throughput: one item per cycle while the output does not stall;
//   the three cordic pipelines run side by side
// reset: aresetn low clears all valid bits and the link registers to zero
// stall: when m_tready is low with a result waiting, the whole pipeline
//   holds and s_tready drops; bubbles stay in place, nothing is lost or repeated
module three_joint_leg_forward_kinematics_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hip_angle [15:0], knee_angle [31:16], ankle_angle [47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // foot_x [15:0], foot_y [31:16], foot_z [47:32], clipped [48], zero pad
    output logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LAT = tjfk_pkg::TOTAL_LAT;

    logic [tjfk_pkg::LINK_W-1:0] hip_len_reg, thigh_len_reg, foot_len_reg;
    logic [LAT-1:0]              valid_reg;
    logic                        en, cfg_wr;

    logic signed [tjfk_pkg::ANG_W-1:0] hip_a, knee_a, sum_a;
    tjfk_pkg::trig_t                   hip_t, knee_t, sum_t;
    logic signed [15:0]                fx, fy, fz;
    logic                              clip;

    // pipeline advances unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    // valid bits move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hip_len_reg   <= '0;
            thigh_len_reg <= '0;
            foot_len_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tjfk_pkg::REG_HIP:   hip_len_reg   <= pwdata[12:0];
                tjfk_pkg::REG_THIGH: thigh_len_reg <= pwdata[12:0];
                tjfk_pkg::REG_FOOT:  foot_len_reg  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tjfk_pkg::REG_HIP:   prdata = {19'd0, hip_len_reg};
            tjfk_pkg::REG_THIGH: prdata = {19'd0, thigh_len_reg};
            tjfk_pkg::REG_FOOT:  prdata = {19'd0, foot_len_reg};
            default:             prdata = '0;
        endcase
    end

    // angles widened; knee plus ankle formed at full width
    assign hip_a  = tjfk_pkg::ANG_W'($signed(s_tdata[15:0]));
    assign knee_a = tjfk_pkg::ANG_W'($signed(s_tdata[31:16]));
    assign sum_a  = knee_a + tjfk_pkg::ANG_W'($signed(s_tdata[47:32]));

    tjfk_cordic u_cordic_hip  (.aclk(aclk), .en(en), .ang(hip_a),  .trig(hip_t));
    tjfk_cordic u_cordic_knee (.aclk(aclk), .en(en), .ang(knee_a), .trig(knee_t));
    tjfk_cordic u_cordic_sum  (.aclk(aclk), .en(en), .ang(sum_a),  .trig(sum_t));

    tjfk_combine u_combine (
        .aclk    (aclk),
        .en      (en),
        .l1      (hip_len_reg),
        .l2      (thigh_len_reg),
        .l3      (foot_len_reg),
        .hip_t   (hip_t),
        .knee_t  (knee_t),
        .sum_t   (sum_t),
        .foot_x  (fx),
        .foot_y  (fy),
        .foot_z  (fz),
        .clipped (clip)
    );

    assign m_tdata = {7'd0, clip, fz, fy, fx};

`ifndef SYNTHESIS
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_cfg_hip: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && paddr[3:2] == tjfk_pkg::REG_HIP) |=> hip_len_reg == $past(pwdata[12:0]))
        else $error("hip link write lost");
`endif

endmodule

@@ rtl/tjfk_cordic.sv @@
// pipelined rotation cordic: angle wrap and fold, one register per stage
module tjfk_cordic (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [tjfk_pkg::ANG_W-1:0]  ang,
    output tjfk_pkg::trig_t                    trig
);
    localparam int N = tjfk_pkg::CORDIC_STAGES;

    logic signed [tjfk_pkg::XY_W-1:0] x_reg [0:N];
    logic signed [tjfk_pkg::XY_W-1:0] y_reg [0:N];
    logic signed [tjfk_pkg::Z_W-1:0]  z_reg [0:N];
    logic                             neg_reg [0:N];
    tjfk_pkg::trig_t                  trig_reg;

    logic signed [tjfk_pkg::ANG_W-1:0] wrap_a, fold_a;
    logic                              fold_neg;

    function automatic logic signed [tjfk_pkg::Z_W-1:0] Z_SHIFT(
        input logic signed [tjfk_pkg::ANG_W-1:0] a);
        logic signed [tjfk_pkg::Z_W-1:0] e;
        e = tjfk_pkg::Z_W'(a);
        return e <<< 15;
    endfunction

    always_comb begin
        if (ang >= tjfk_pkg::HALF_TURN) begin
            wrap_a = ang - tjfk_pkg::FULL_TURN;
        end else if (ang < -tjfk_pkg::HALF_TURN) begin
            wrap_a = ang + tjfk_pkg::FULL_TURN;
        end else begin
            wrap_a = ang;
        end
        fold_neg = 1'b1;
        if (wrap_a > tjfk_pkg::QUARTER_TURN) begin
            fold_a = wrap_a - tjfk_pkg::HALF_TURN;
        end else if (wrap_a < -tjfk_pkg::QUARTER_TURN) begin
            fold_a = wrap_a + tjfk_pkg::HALF_TURN;
        end else begin
            fold_a   = wrap_a;
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= tjfk_pkg::CORDIC_K;
            y_reg[0]   <= '0;
            z_reg[0]   <= Z_SHIFT(fold_a);
            neg_reg[0] <= fold_neg;
            for (int i = 0; i < N; i++) begin
                if (!z_reg[i][tjfk_pkg::Z_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - tjfk_pkg::atan_val(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + tjfk_pkg::atan_val(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
            trig_reg.cos_val <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            trig_reg.sin_val <= neg_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign trig = trig_reg;

endmodule

@@ rtl/tjfk_combine.sv @@
// link products, reach, rounding and saturation of the foot coordinates
module tjfk_combine (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [tjfk_pkg::LINK_W-1:0]        l1,
    input  logic [tjfk_pkg::LINK_W-1:0]        l2,
    input  logic [tjfk_pkg::LINK_W-1:0]        l3,
    input  tjfk_pkg::trig_t                    hip_t,
    input  tjfk_pkg::trig_t                    knee_t,
    input  tjfk_pkg::trig_t                    sum_t,
    output logic signed [15:0]                 foot_x,
    output logic signed [15:0]                 foot_y,
    output logic signed [15:0]                 foot_z,
    output logic                               clipped
);
    localparam int PW = tjfk_pkg::PROD_W;

    logic signed [PW-1:0] p_ck_reg, p_cka_reg, p_sk_reg, p_ska_reg;
    tjfk_pkg::trig_t      hip_a_reg, hip_b_reg;
    logic signed [31:0]   r14_reg;
    logic signed [PW-1:0] zsum_reg;
    logic signed [65:0]   px_reg, py_reg;
    logic signed [17:0]   zr_reg;
    logic signed [15:0]   x_reg, y_reg, z_reg;
    logic                 clip_reg;

    logic signed [13:0]   l2s, l3s;
    logic signed [PW-1:0] r30;
    logic signed [21:0]   xr, yr;
    logic                 cx, cy, cz;

    assign l2s = $signed({1'b0, l2});
    assign l3s = $signed({1'b0, l3});

    always_comb begin
        r30 = $signed({{(PW-43){1'b0}}, l1, 30'd0}) + p_ck_reg + p_cka_reg + PW'(32768);
        xr  = 22'((px_reg + (66'sd1 <<< 43)) >>> 44);
        yr  = 22'((py_reg + (66'sd1 <<< 43)) >>> 44);
        cx  = (xr > 22'sd32767) || (xr < -22'sd32768);
        cy  = (yr > 22'sd32767) || (yr < -22'sd32768);
        cz  = (zr_reg > 18'sd32767) || (zr_reg < -18'sd32768);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ck_reg  <= PW'(l2s * knee_t.cos_val);
            p_cka_reg <= PW'(l3s * sum_t.cos_val);
            p_sk_reg  <= PW'(l2s * knee_t.sin_val);
            p_ska_reg <= PW'(l3s * sum_t.sin_val);
            hip_a_reg <= hip_t;

            r14_reg   <= 32'(r30 >>> 16);
            zsum_reg  <= -(p_sk_reg + p_ska_reg);
            hip_b_reg <= hip_a_reg;

            px_reg    <= 66'(r14_reg * hip_b_reg.cos_val);
            py_reg    <= 66'(r14_reg * hip_b_reg.sin_val);
            zr_reg    <= 18'((zsum_reg + (PW'(1) <<< 29)) >>> 30);

            x_reg    <= cx ? (xr[21] ? -16'sd32768 : 16'sd32767) : xr[15:0];
            y_reg    <= cy ? (yr[21] ? -16'sd32768 : 16'sd32767) : yr[15:0];
            z_reg    <= cz ? (zr_reg[17] ? -16'sd32768 : 16'sd32767) : zr_reg[15:0];
            clip_reg <= cx || cy || cz;
        end
    end

    assign foot_x  = x_reg;
    assign foot_y  = y_reg;
    assign foot_z  = z_reg;
    assign clipped = clip_reg;

endmodule

@@ tb/tb_top.sv @@
// testbench for the three-joint leg forward kinematics block
`timescale 1ns / 1ps

module tb_top;

    localparam int  N_RANDOM    = 400;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_WAIT  = tjfk_pkg::TOTAL_LAT + 8;
    localparam int  ATAN_N      = 24;
    localparam int  TURN_HALF   = 23040;
    localparam int  TURN_FULL   = 46080;
    localparam int  TURN_QTR    = 11520;

    // arctangent of 2^-i in units of 2^-22 degree
    localparam longint ATAN_Q22 [ATAN_N] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };
    localparam longint GAIN_Q30 = 652032875;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               clip;
    } foot_pos_t;

    typedef struct {
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic signed [15:0] ankle;
        bit                 typed;   // expectation typed in below
        foot_pos_t          pos;
    } angle_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // hip_angle [15:0], knee_angle [31:16], ankle_angle [47:32]
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // foot_x [15:0], foot_y [31:16], foot_z [47:32], clipped [48], zero pad
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the link registers
    logic [12:0] len_hip, len_thigh, len_foot;

    foot_pos_t   pos_queue [$];
    foot_pos_t   typed_queue [$];  // typed-in values, used only where typed_flag is set
    bit          typed_flag [$];
    int          n_errors;
    int          n_items;
    int          n_results;
    int          cycles;
    bit          quiet;

    three_joint_leg_forward_kinematics_top i_dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // cordic sine and cosine of an angle in 1/128 degree, both q30
    function automatic void trig_q30(input int a, output longint c, output longint s);
        int     m;
        bit     flip;
        longint x, y, z, dx, dy;
        int     n;
        m    = a % TURN_FULL;
        flip = 1'b0;
        x    = GAIN_Q30;
        y    = 0;
        if (m >= TURN_HALF) m -= TURN_FULL;
        if (m < -TURN_HALF) m += TURN_FULL;
        // fold into the right half plane by a half turn
        if (m > TURN_QTR) begin
            m -= TURN_HALF;
            flip = 1'b1;
        end else if (m < -TURN_QTR) begin
            m += TURN_HALF;
            flip = 1'b1;
        end
        z = longint'(m) * 32768;
        n = (tjfk_pkg::CORDIC_STAGES > ATAN_N) ? ATAN_N : tjfk_pkg::CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_Q22[i];
            end else begin
                x += dx; y -= dy; z += ATAN_Q22[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // round to nearest, ties upward, then clamp to 16 bits
    function automatic logic signed [15:0] round_sat(input longint v, input int sh,
                                                     inout logic clip);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 32767) begin
            r = 32767; clip = 1'b1;
        end
        if (r < -32768) begin
            r = -32768; clip = 1'b1;
        end
        return r[15:0];
    endfunction

    function automatic foot_pos_t foot_position(input logic signed [15:0] hip,
                                                input logic signed [15:0] knee,
                                                input logic signed [15:0] ankle);
        foot_pos_t p;
        longint    ch, sh, ck, sk, cka, ska, r30, r14, zsum;
        logic      clip;
        clip = 1'b0;
        trig_q30(int'(hip), ch, sh);
        trig_q30(int'(knee), ck, sk);
        trig_q30(int'(knee) + int'(ankle), cka, ska);
        r30  = (longint'(len_hip) <<< 30) + longint'(len_thigh) * ck
             + longint'(len_foot) * cka;
        r14  = (r30 + (longint'(1) <<< 15)) >>> 16;
        zsum = -(longint'(len_thigh) * sk + longint'(len_foot) * ska);
        p.x  = round_sat(r14 * ch, 44, clip);
        p.y  = round_sat(r14 * sh, 44, clip);
        p.z  = round_sat(zsum, 30, clip);
        p.clip = clip;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // every accepted input item gets its expectation here
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pos_queue.push_back(foot_position(s_tdata[15:0], s_tdata[31:16],
                                              s_tdata[47:32]));
            n_items++;
        end
    end

    // every accepted result is compared with the oldest expectation
    always @(posedge aclk) begin
        foot_pos_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[15:0];
            got.y    = m_tdata[31:16];
            got.z    = m_tdata[47:32];
            got.clip = m_tdata[48];
            n_results++;
            if (pos_queue.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pos_queue.pop_front();
                // a typed-in row must agree with the predictor as well
                if (typed_flag.size() > 0 && typed_flag.pop_front()) begin
                    if (typed_queue.pop_front() != want)
                        report_mismatch("typed expectation disagrees with predictor");
                end
                if (got.x !== want.x)
                    report_mismatch($sformatf("foot_x %0d, want %0d", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("foot_y %0d, want %0d", got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("foot_z %0d, want %0d", got.z, want.z));
                if (got.clip !== want.clip)
                    report_mismatch($sformatf("clipped %0b, want %0b", got.clip, want.clip));
                if (m_tdata[55:49] !== '0)
                    report_mismatch("padding bits not zero");
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // result side back-pressure, random bursts of stall
    // ---------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // apb write: setup then access cycle
    task automatic write_link(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (addr)
            4 * tjfk_pkg::REG_HIP:   len_hip   = value[12:0];
            4 * tjfk_pkg::REG_THIGH: len_thigh = value[12:0];
            4 * tjfk_pkg::REG_FOOT:  len_foot  = value[12:0];
            default: ;  // unmapped addresses change nothing
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all three links, upper bits of the bus set at random to test masking
    task automatic set_links(input logic [12:0] l1, input logic [12:0] l2,
                             input logic [12:0] l3);
        write_link(4 * tjfk_pkg::REG_HIP,   {$urandom_range(0, 1) ? 19'h7ffff : 19'h0, l1});
        write_link(4 * tjfk_pkg::REG_THIGH, {$urandom_range(0, 1) ? 19'h7ffff : 19'h0, l2});
        write_link(4 * tjfk_pkg::REG_FOOT,  {$urandom_range(0, 1) ? 19'h7ffff : 19'h0, l3});
    endtask

    // send one item, with a random gap in front unless quiet
    task automatic send_angles(input logic [15:0] hip, input logic [15:0] knee,
                               input logic [15:0] ankle);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ankle, knee, hip};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pos_queue.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // mostly in-range angles, sometimes any 16-bit pattern to exercise the wrap
    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 2 * TURN_HALF)) - TURN_HALF);
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    angle_row_t dir_tab [$];

    initial begin
        foot_pos_t zero_pos;
        angle_row_t row;
        zero_pos  = '{x: 0, y: 0, z: 0, clip: 0};
        n_errors  = 0;
        n_items   = 0;
        n_results = 0;
        cycles    = 0;
        quiet     = 1'b0;
        len_hip   = '0;
        len_thigh = '0;
        len_foot  = '0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        // directed table: rows with typed expectations run with links at reset
        dir_tab.push_back('{0, 0, 0, 1, zero_pos});
        dir_tab.push_back('{16'sd23040, -16'sd23040, 16'sd23040, 1, zero_pos});
        dir_tab.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 1, zero_pos});
        dir_tab.push_back('{0, 0, 0, 0, zero_pos});
        dir_tab.push_back('{16'sd23040, 16'sd11520, -16'sd11520, 0, zero_pos});
        dir_tab.push_back('{-16'sd23040, -16'sd11520, 16'sd11520, 0, zero_pos});
        dir_tab.push_back('{16'sd11520, 16'sd11521, -16'sd11521, 0, zero_pos});
        dir_tab.push_back('{-16'sd11520, -16'sd11519, 16'sd11519, 0, zero_pos});
        // knee plus ankle beyond a half turn, summed at full width
        dir_tab.push_back('{16'sd5760, 16'sd23040, 16'sd23040, 0, zero_pos});
        dir_tab.push_back('{-16'sd5760, -16'sd23040, -16'sd23040, 0, zero_pos});
        dir_tab.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, zero_pos});
        dir_tab.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 0, zero_pos});
        dir_tab.push_back('{16'sd23039, -16'sd23039, 16'sd1, 0, zero_pos});
        dir_tab.push_back('{16'sd1, -16'sd1, 16'sd0, 0, zero_pos});
        dir_tab.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 0, zero_pos});
        dir_tab.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 0, zero_pos});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // links still at reset: every coordinate must come out zero
        foreach (dir_tab[i]) begin
            if (dir_tab[i].typed) begin
                typed_flag.push_back(1'b1);
                typed_queue.push_back(dir_tab[i].pos);
                send_angles(dir_tab[i].hip, dir_tab[i].knee, dir_tab[i].ankle);
            end
        end
        drain();

        // longest links, all rows checked against the predictor
        set_links(13'h1fff, 13'h1fff, 13'h1fff);
        write_link(4'hc, 32'hffff_ffff);  // unmapped, must be ignored
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            typed_flag.push_back(1'b0);
            send_angles(row.hip, row.knee, row.ankle);
        end
        drain();
        typed_flag.delete();

        random_items(N_RANDOM / 4);
        drain();

        set_links(13'h0, 13'h1fff, 13'h0);
        random_items(N_RANDOM / 4);
        drain();

        set_links(13'($urandom), 13'($urandom), 13'($urandom));
        random_items(N_RANDOM / 4);
        drain();

        // last stretch with neither side idling
        set_links(13'h1fff, 13'h0, 13'h1);
        quiet = 1'b1;
        random_items(N_RANDOM / 4);
        drain();

        $display("sent %0d items, checked %0d results over five link settings",
                 n_items, n_results);
        $display("angles covered wrap, fold and full-width knee plus ankle sums");
        if (n_errors == 0 && pos_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
